FILE: hdl/lphm_pkg.sv
// ----------------------------------------------------------------------------
// lphm_pkg
// Types and constants shared by the linear probing hash map: the payload
// structs of both channels, the command queue entry and the code values.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned STEP_W     = $clog2(HASH_W);
  localparam int unsigned HOME_W     = 16;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned OCC_W      = 11;
  localparam int unsigned LIMIT_W    = 11;
  localparam logic [HASH_W-1:0]  HASH_SEED   = 32'd5381;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd922;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key_in;
    logic [63:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [63:0]           value_out;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [OCC_W-1:0]      occupancy;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [63:0]       key;
    logic [63:0]       value;
    logic [HOME_W-1:0] home;
  } cmd_t;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_PUSH} front_state_t;

  typedef enum logic [2:0] {B_SWEEP, B_IDLE, B_READ, B_CHECK, B_REPLY} back_state_t;

endpackage

FILE: hdl/linear_probe_hash_map_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_map_top
// Key/value map with linear probing over a fixed slot array.
// ----------------------------------------------------------------------------
//  Channel   Ports                      Beat moves when
//  command   in_item, push, full        push && !full
//  result    out_item, empty, pop       pop && !empty
//  limit     cfg_data, cfg_valid/ready  cfg_valid && cfg_ready
//
// The front handles one command at a time: it accepts the beat, hashes one
// byte of the key a cycle, reduces the hash to the home slot by reciprocal
// multiplication (product, quotient, remainder) and hands it to the queue.
// The back takes a command, reads each probed slot from registered memory
// and then compares it, and posts the result; clear sweeps every slot first.
// After reset a clearing pass over every slot runs with full held high.
// A result waiting in the output register stalls the back; the front and the
// two-entry command queue keep taking commands until the front waits on a full
// queue.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_top #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned KEY_BYTES   = 8,
  parameter int unsigned VALUE_BITS  = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lphm_pkg::in_item_t           in_item,
  input  logic                         push,
  output logic                         full,
  output lphm_pkg::out_item_t          out_item,
  output logic                         empty,
  input  logic                         pop,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lphm_pkg::LIMIT_W-1:0] cfg_data
);
  import lphm_pkg::*;

  cmd_t f_data, q_data;
  logic f_push, f_full, q_pop, q_empty, init_busy;

  assign cfg_ready = 1'b1;

  lphm_front #(
    .TABLE_SLOTS(TABLE_SLOTS), .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .push(push), .full(full),
    .init_busy(init_busy), .q_data(f_data), .q_push(f_push), .q_full(f_full)
  );

  lphm_cmd_fifo #(.DEPTH(2)) u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_data(f_data), .wr_en(f_push), .wr_full(f_full),
    .rd_data(q_data), .rd_en(q_pop), .rd_empty(q_empty)
  );

  lphm_back #(
    .TABLE_SLOTS(TABLE_SLOTS), .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_empty(q_empty), .q_pop(q_pop),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data), .out_item(out_item),
    .empty(empty), .pop(pop), .init_busy(init_busy)
  );

endmodule

FILE: hdl/lphm_front.sv
// ----------------------------------------------------------------------------
// lphm_front
// Accepts a command beat, hashes the key one byte a cycle and reduces the
// hash to a home slot by multiplying with a fixed reciprocal.
// ----------------------------------------------------------------------------
module lphm_front #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned KEY_BYTES   = 8,
  parameter int unsigned VALUE_BITS  = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lphm_pkg::in_item_t in_item,
  input  logic              push,
  output logic              full,
  input  logic              init_busy,
  output lphm_pkg::cmd_t    q_data,
  output logic              q_push,
  input  logic              q_full
);
  import lphm_pkg::*;

  localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned KEY_W  = 8 * KEY_BYTES;
  localparam logic [63:0] KEY_MASK = 64'((65'(1) << KEY_W) - 65'(1));
  localparam logic [63:0] VAL_MASK = 64'((65'(1) << VALUE_BITS) - 65'(1));
  // Reciprocal of the slot count for a 32-bit dividend, with
  // 2^(SLOT_W-1) < TABLE_SLOTS <= 2^SLOT_W.
  localparam logic [63:0] RECIP_FULL =
    ((((64'd1 << SLOT_W) - 64'(TABLE_SLOTS)) << HASH_W) / 64'(TABLE_SLOTS)) + 64'd1;
  localparam logic [HASH_W-1:0] RECIP = RECIP_FULL[HASH_W-1:0];

  front_state_t state_r, state_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [63:0]         key_r, key_nxt;
  logic [63:0]         val_r, val_nxt;
  logic [63:0]         sh_r, sh_nxt;
  logic [HASH_W-1:0]   h_r, h_nxt;
  logic [SLOT_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [2*HASH_W-1:0] prod_r, prod_nxt;
  logic [HASH_W-1:0]   quo_r, quo_nxt;
  logic [HASH_W-1:0]   prod_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    sh_r   <= sh_nxt;
    h_r    <= h_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    sh_nxt    = sh_r;
    h_nxt     = h_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    quo_nxt   = quo_r;
    prod_hi   = prod_r[2*HASH_W-1:HASH_W];
    full      = (state_r != F_IDLE) || init_busy;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (push && !full) begin
          cmd_nxt   = in_item.command;
          key_nxt   = in_item.key_in & KEY_MASK;
          val_nxt   = in_item.value_in & VAL_MASK;
          sh_nxt    = in_item.key_in;
          h_nxt     = HASH_SEED;
          step_nxt  = STEP_W'(KEY_BYTES - 1);
          state_nxt = F_HASH;
        end
      end
      F_HASH: begin
        // h * 33 + byte, byte 0 first.
        h_nxt    = (h_r << 5) + h_r + HASH_W'(sh_r[7:0]);
        sh_nxt   = sh_r >> 8;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          step_nxt  = STEP_W'(2);
          state_nxt = F_MOD;
        end
      end
      F_MOD: begin
        // Quotient from the high half of h times the reciprocal, then the
        // remainder as h minus quotient times the slot count.
        step_nxt = step_r - STEP_W'(1);
        priority if (step_r == STEP_W'(2)) begin
          prod_nxt = (2*HASH_W)'(h_r) * (2*HASH_W)'(RECIP);
        end else if (step_r == STEP_W'(1)) begin
          quo_nxt = (prod_hi + ((h_r - prod_hi) >> 1)) >> (SLOT_W - 1);
        end else begin
          rem_nxt   = SLOT_W'(h_r - HASH_W'(quo_r * HASH_W'(TABLE_SLOTS)));
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_data = '{command: cmd_r, key: key_r, value: val_r, home: HOME_W'(rem_r)};

endmodule

FILE: hdl/lphm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lphm_cmd_fifo
// Short command queue between the hashing front and the probing back.
// ----------------------------------------------------------------------------
module lphm_cmd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lphm_pkg::cmd_t wr_data,
  input  logic           wr_en,
  output logic           wr_full,
  output lphm_pkg::cmd_t rd_data,
  input  logic           rd_en,
  output logic           rd_empty
);
  import lphm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_full  = (cnt_r == CNT_W'(DEPTH));
  assign rd_empty = (cnt_r == '0);
  assign do_wr    = wr_en && !wr_full;
  assign do_rd    = rd_en && !rd_empty;
  assign rd_data  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

FILE: hdl/lphm_back.sv
// ----------------------------------------------------------------------------
// lphm_back
// Probe engine: holds the slot memories, walks slots from home, applies the
// command, sweeps the valid map on reset and on clear, and keeps the result.
// ----------------------------------------------------------------------------
module lphm_back #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned KEY_BYTES   = 8,
  parameter int unsigned VALUE_BITS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lphm_pkg::cmd_t                q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic                          cfg_valid,
  input  logic [lphm_pkg::LIMIT_W-1:0]  cfg_data,
  output lphm_pkg::out_item_t           out_item,
  output logic                          empty,
  input  logic                          pop,
  output logic                          init_busy
);
  import lphm_pkg::*;

  localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned KEY_W  = 8 * KEY_BYTES;

  logic                  vld_mem [TABLE_SLOTS];
  logic [KEY_W-1:0]      key_mem [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] val_mem [TABLE_SLOTS];

  back_state_t state_r, state_nxt;
  cmd_t                  cur_r, cur_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [CNT_W-1:0]      probes_r, probes_nxt;
  logic [SLOT_W-1:0]     sweep_r, sweep_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [LIMIT_W-1:0]    limit_r;
  logic                  init_r, init_nxt;
  logic [2:0]            rs_status_r, rs_status_nxt;
  logic [63:0]           rs_value_r, rs_value_nxt;
  logic [SLOT_W-1:0]     rs_slot_r, rs_slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic                  rd_en;
  logic                  vld_q_r;
  logic [KEY_W-1:0]      key_q_r;
  logic [VALUE_BITS-1:0] val_q_r;
  logic                  vld_we, vld_wd, kv_we, val_we;
  logic [SLOT_W-1:0]     wr_addr;
  logic                  key_eq, last_probe;

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[wr_addr] <= vld_wd;
    end
    if (kv_we) begin
      key_mem[wr_addr] <= KEY_W'(cur_r.key);
    end
    if (val_we) begin
      val_mem[wr_addr] <= VALUE_BITS'(cur_r.value);
    end
    if (rd_en) begin
      vld_q_r <= vld_mem[slot_r];
      key_q_r <= key_mem[slot_r];
      val_q_r <= val_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_SWEEP;
      sweep_r     <= '0;
      count_r     <= '0;
      limit_r     <= LIMIT_RESET;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      count_r     <= count_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
    end
    cur_r       <= cur_nxt;
    slot_r      <= slot_nxt;
    probes_r    <= probes_nxt;
    rs_status_r <= rs_status_nxt;
    rs_value_r  <= rs_value_nxt;
    rs_slot_r   <= rs_slot_nxt;
    out_r       <= out_nxt;
  end

  assign key_eq     = (key_q_r == KEY_W'(cur_r.key));
  assign last_probe = (probes_r + CNT_W'(1)) == CNT_W'(TABLE_SLOTS);
  assign init_busy  = init_r;
  assign empty      = !out_valid_r;
  assign out_item   = out_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    sweep_nxt     = sweep_r;
    count_nxt     = count_r;
    init_nxt      = init_r;
    rs_status_nxt = rs_status_r;
    rs_value_nxt  = rs_value_r;
    rs_slot_nxt   = rs_slot_r;
    out_valid_nxt = out_valid_r && !pop;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    vld_we        = 1'b0;
    vld_wd        = 1'b0;
    kv_we         = 1'b0;
    val_we        = 1'b0;
    wr_addr       = slot_r;
    unique case (state_r)
      B_SWEEP: begin
        vld_we    = 1'b1;
        wr_addr   = sweep_r;
        sweep_nxt = sweep_r + SLOT_W'(1);
        if (sweep_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          sweep_nxt = '0;
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = B_IDLE;
          end else begin
            count_nxt     = '0;
            rs_status_nxt = ST_CLEARED;
            rs_value_nxt  = '0;
            rs_slot_nxt   = '0;
            state_nxt     = B_REPLY;
          end
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cur_nxt    = q_data;
          slot_nxt   = SLOT_W'(q_data.home);
          probes_nxt = '0;
          state_nxt  = (q_data.command == CMD_CLEAR) ? B_SWEEP : B_READ;
        end
      end
      B_READ: begin
        rd_en     = 1'b1;
        state_nxt = B_CHECK;
      end
      B_CHECK: begin
        rs_value_nxt = '0;
        rs_slot_nxt  = '0;
        if (cur_r.command == CMD_INSERT && (!vld_q_r || key_eq)) begin
          state_nxt = B_REPLY;
          if (vld_q_r) begin
            val_we        = 1'b1;
            rs_status_nxt = ST_UPDATED;
            rs_slot_nxt   = slot_r;
          end else if (32'(count_r) >= 32'(limit_r)) begin
            rs_status_nxt = ST_FULL;
          end else begin
            vld_we        = 1'b1;
            vld_wd        = 1'b1;
            kv_we         = 1'b1;
            val_we        = 1'b1;
            count_nxt     = count_r + CNT_W'(1);
            rs_status_nxt = ST_INSERTED;
            rs_slot_nxt   = slot_r;
          end
        end else if (cur_r.command != CMD_INSERT && vld_q_r && key_eq) begin
          state_nxt   = B_REPLY;
          rs_slot_nxt = slot_r;
          if (cur_r.command == CMD_LOOKUP) begin
            rs_status_nxt = ST_FOUND;
            rs_value_nxt  = 64'(val_q_r);
          end else begin
            vld_we        = 1'b1;
            rs_status_nxt = ST_REMOVED;
            if (count_r != '0) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end else if (last_probe) begin
          // Every slot has been looked at without a hit.
          state_nxt     = B_REPLY;
          rs_status_nxt = (cur_r.command == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end else begin
          probes_nxt = probes_r + CNT_W'(1);
          slot_nxt   = (slot_r == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
          state_nxt  = B_READ;
        end
      end
      B_REPLY: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status:     rs_status_r,
                            value_out:  rs_value_r,
                            slot_index: SLOT_OUT_W'(rs_slot_r),
                            occupancy:  OCC_W'(count_r)};
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

endmodule

FILE: hdl/lphm_checker.sv
// ----------------------------------------------------------------------------
// lphm_props
// Port-level checks on the result channel of the hash map.
// ----------------------------------------------------------------------------
module lphm_props (
  input logic                clk,
  input logic                rst_n,
  input lphm_pkg::out_item_t out_item,
  input logic                empty,
  input logic                pop
);
  import lphm_pkg::*;

  // Only a found key carries a value.
  a_value_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.status != ST_FOUND |-> out_item.value_out == '0)
    else $error("value_out non-zero on a result other than found");

  // Misses, refusals and clears name no slot.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_item.status == ST_NOT_FOUND || out_item.status == ST_FULL ||
               out_item.status == ST_CLEARED) |-> out_item.slot_index == '0)
    else $error("slot_index non-zero on a result without a slot");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.status == ST_CLEARED |-> out_item.occupancy == '0)
    else $error("occupancy non-zero after clear");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed or vanished");

endmodule

bind linear_probe_hash_map_top lphm_props u_lphm_props (.*);
